>>> rtl/ps2mpt_pkg.sv
// shared types and constants for the ps2 mouse pointer tracker
// no dependencies
package ps2mpt_pkg;

	// header byte flags
	localparam logic [7:0] HDR_VALID = 8'h08;
	localparam logic [7:0] HDR_XSIGN = 8'h10;
	localparam logic [7:0] HDR_YSIGN = 8'h20;

	// position of the next beat within a packet
	typedef logic [1:0] byte_idx_t;
	localparam byte_idx_t IDX_HEADER = 2'd0;
	localparam byte_idx_t IDX_XMOVE  = 2'd1;
	localparam byte_idx_t IDX_YMOVE  = 2'd2;

	// movement values and coordinate sums
	localparam int MOVE_W = 9;
	localparam int SUM_W  = 11;
	typedef logic signed [MOVE_W-1:0] move_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// fixed output field widths
	localparam int POS_X_W = 7;
	localparam int POS_Y_W = 5;

endpackage

>>> rtl/ps2_mouse_pointer_tracker_top.sv
// ps2 mouse pointer tracker: three-byte packet decoder and clamped pointer
// depends on ps2mpt_pkg
//
// usage
//   input channel: in_valid / in_ready / aux_byte, one raw mouse byte per beat
//   output channel: out_valid / out_ready / pos_x / pos_y / moved
//   every third input beat closes a packet; a packet whose header has bit 3
//   set yields one output beat with the new pointer position, a packet with
//   bit 3 clear yields nothing and the pointer stays put
//   latency: the output beat is valid in the cycle after the third byte is
//   accepted
//   throughput: one input beat per cycle while in_ready is high; the only
//   stored work is the packet byte counter, the two held bytes and the
//   pointer position, all updated in the accepting cycle
//   stall: a single output register holds the result; in_ready stays high
//   while that register is empty or is being drained in the same cycle, so a
//   stalled receiver holds off input only once a result is waiting
//   reset: counter and held bytes cleared, pointer at the screen center,
//   output register empty
module ps2_mouse_pointer_tracker_top #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] aux_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [ps2mpt_pkg::POS_X_W-1:0] pos_x,
	output logic [ps2mpt_pkg::POS_Y_W-1:0] pos_y,
	output logic       moved
);

	localparam int COL_W = (SCREEN_COLUMNS > 2) ? $clog2(SCREEN_COLUMNS) : 1;
	localparam int ROW_W = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
	localparam logic [COL_W-1:0] COL_RESET = COL_W'(SCREEN_COLUMNS / 2);
	localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(SCREEN_ROWS / 2);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
	localparam ps2mpt_pkg::sum_t COL_LIMIT = ps2mpt_pkg::sum_t'(SCREEN_COLUMNS);
	localparam ps2mpt_pkg::sum_t ROW_LIMIT = ps2mpt_pkg::sum_t'(SCREEN_ROWS);

	ps2mpt_pkg::byte_idx_t byte_idx_q;
	logic [7:0]            header_q;
	logic [7:0]            xbyte_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic                  out_valid_q;
	logic [ps2mpt_pkg::POS_X_W-1:0] pos_x_q;
	logic [ps2mpt_pkg::POS_Y_W-1:0] pos_y_q;
	logic                  moved_q;

	logic                  in_fire;
	logic                  last_beat;
	logic                  pkt_ok;
	ps2mpt_pkg::move_t     dx;
	ps2mpt_pkg::move_t     dy_raw;
	ps2mpt_pkg::sum_t      col_sum;
	ps2mpt_pkg::sum_t      row_sum;
	logic [COL_W-1:0]      col_next;
	logic [ROW_W-1:0]      row_next;
	logic                  move_nz;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign last_beat = (byte_idx_q != ps2mpt_pkg::IDX_HEADER)
		&& (byte_idx_q != ps2mpt_pkg::IDX_XMOVE);
	assign pkt_ok    = (header_q & ps2mpt_pkg::HDR_VALID) != 8'h00;

	// nine-bit movements, sign bits from the header
	assign dx     = {(header_q & ps2mpt_pkg::HDR_XSIGN) != 8'h00, xbyte_q};
	assign dy_raw = {(header_q & ps2mpt_pkg::HDR_YSIGN) != 8'h00, aux_byte};
	assign move_nz = (dx != '0) || (dy_raw != '0);

	// screen rows grow downward, so y is subtracted
	assign col_sum = ps2mpt_pkg::sum_t'(col_q) + ps2mpt_pkg::sum_t'(dx);
	assign row_sum = ps2mpt_pkg::sum_t'(row_q) - ps2mpt_pkg::sum_t'(dy_raw);

	always_comb begin
		if (col_sum < 0) begin
			col_next = '0;
		end else if (col_sum >= COL_LIMIT) begin
			col_next = COL_LAST;
		end else begin
			col_next = col_sum[COL_W-1:0];
		end
		if (row_sum < 0) begin
			row_next = '0;
		end else if (row_sum >= ROW_LIMIT) begin
			row_next = ROW_LAST;
		end else begin
			row_next = row_sum[ROW_W-1:0];
		end
	end

	// packet collection and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= ps2mpt_pkg::IDX_HEADER;
			header_q   <= '0;
			xbyte_q    <= '0;
			col_q      <= COL_RESET;
			row_q      <= ROW_RESET;
		end else if (in_fire) begin
			case (byte_idx_q)
				ps2mpt_pkg::IDX_HEADER: begin
					header_q   <= aux_byte;
					byte_idx_q <= ps2mpt_pkg::IDX_XMOVE;
				end
				ps2mpt_pkg::IDX_XMOVE: begin
					xbyte_q    <= aux_byte;
					byte_idx_q <= ps2mpt_pkg::IDX_YMOVE;
				end
				default: begin
					byte_idx_q <= ps2mpt_pkg::IDX_HEADER;
					if (pkt_ok && move_nz) begin
						col_q <= col_next;
						row_q <= row_next;
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && last_beat && pkt_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_beat && pkt_ok) begin
			if (move_nz) begin
				pos_x_q <= ps2mpt_pkg::POS_X_W'(col_next);
				pos_y_q <= ps2mpt_pkg::POS_Y_W'(row_next);
			end else begin
				pos_x_q <= ps2mpt_pkg::POS_X_W'(col_q);
				pos_y_q <= ps2mpt_pkg::POS_Y_W'(row_q);
			end
			moved_q <= move_nz;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign moved     = moved_q;

	// pointer stays on the grid
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST)
		else $error("pointer column off screen");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("pointer row off screen");

	// a result only follows the closing byte of a packet
	a_result_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_fire && last_beat))
		else $error("result without closing byte");

	// pointer only moves on a closing byte
	a_move_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && last_beat) |=> ($stable(col_q) && $stable(row_q)))
		else $error("pointer moved mid packet");

	// counter never reaches the unused code
	a_idx_legal: assert property (@(posedge clk) disable iff (!arst_n)
		byte_idx_q <= ps2mpt_pkg::IDX_YMOVE)
		else $error("byte counter out of range");

endmodule
